FILE: rtl/iplpm_pkg.sv
// ----------------------------------------------------------------------------
// iplpm_pkg
// Shared types, codes and helpers of the IPv4 longest-prefix-match table.
// ----------------------------------------------------------------------------
package iplpm_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP    = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] base;
    } t_entry;

    typedef struct packed {
        logic exact;
        logic covers;
    } t_cmp_res;

    // top len bits set; len is at most 32
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else begin
            m = {ADDR_W{1'b1}} << (LEN_MAX - len);
        end
        return m;
    endfunction

endpackage

FILE: rtl/ipv4_longest_prefix_match_table.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_table
// Keeps up to TABLE_ENTRIES IPv4 prefixes and serves insert, delete and lookup
// beats. Every insert, delete or lookup walks the whole store through one
// compare unit, one entry per cycle off the single read port of the memory,
// before its result goes to the result register; an undefined kind skips the
// walk. After reset a clearing pass writes every entry before the first beat
// is taken. The result sits in an output register, so the next beat is
// accepted while a result still waits to be taken.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match_table #(
    parameter int TABLE_ENTRIES = iplpm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [iplpm_pkg::KIND_W-1:0] i_kind,
    input  logic [iplpm_pkg::ADDR_W-1:0] i_address,
    input  logic [iplpm_pkg::LEN_W-1:0]  i_prefix_length,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [iplpm_pkg::STAT_W-1:0] o_status,
    output logic                         o_match_found,
    output logic [iplpm_pkg::LEN_W-1:0]  o_match_length
);
    import iplpm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_chk, n_chk;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;

    logic [KIND_W-1:0] r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] r_key_base, n_key_base;
    logic [LEN_W-1:0]  r_len, n_len;

    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic              r_free, n_free;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic              r_found, n_found;
    logic [LEN_W-1:0]  r_best, n_best;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_match_found, n_match_found;
    logic [LEN_W-1:0]  r_match_length, n_match_length;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    t_entry            mem_rdata;
    t_cmp_res          cmp_res;

    logic [LEN_W-1:0]  in_len;
    logic [STAT_W-1:0] done_status;

    iplpm_mem #(
        .DEPTH (TABLE_ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    iplpm_cmp u_cmp (
        .i_entry    (mem_rdata),
        .i_key_base (r_key_base),
        .i_key_len  (r_len),
        .i_addr     (r_addr),
        .o_res      (cmp_res)
    );

    assign in_len = (i_prefix_length > LEN_MAX) ? LEN_MAX : i_prefix_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cnt          <= n_cnt;
            r_chk          <= n_chk;
            r_out_valid    <= n_out_valid;
            r_chk_idx      <= n_chk_idx;
            r_kind         <= n_kind;
            r_addr         <= n_addr;
            r_key_base     <= n_key_base;
            r_len          <= n_len;
            r_hit          <= n_hit;
            r_hit_idx      <= n_hit_idx;
            r_free         <= n_free;
            r_free_idx     <= n_free_idx;
            r_found        <= n_found;
            r_best         <= n_best;
            r_status       <= n_status;
            r_match_found  <= n_match_found;
            r_match_length <= n_match_length;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_chk          = r_chk;
        n_chk_idx      = r_chk_idx;
        n_kind         = r_kind;
        n_addr         = r_addr;
        n_key_base     = r_key_base;
        n_len          = r_len;
        n_hit          = r_hit;
        n_hit_idx      = r_hit_idx;
        n_free         = r_free;
        n_free_idx     = r_free_idx;
        n_found        = r_found;
        n_best         = r_best;
        n_out_valid    = r_out_valid;
        n_status       = r_status;
        n_match_found  = r_match_found;
        n_match_length = r_match_length;

        mem_we    = 1'b0;
        mem_waddr = r_cnt[IDX_W-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_cnt[IDX_W-1:0];
        done_status = ST_OK;

        // entry read last cycle is checked now
        if (r_chk) begin
            if (cmp_res.exact && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_chk_idx;
            end
            if (!mem_rdata.valid && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_chk_idx;
            end
            if (cmp_res.covers && (!r_found || (mem_rdata.len > r_best))) begin
                n_found = 1'b1;
                n_best  = mem_rdata.len;
            end
        end

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind     = i_kind;
                    n_addr     = i_address;
                    n_len      = in_len;
                    n_key_base = i_address & len_mask(in_len);
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                    n_found    = 1'b0;
                    n_best     = '0;
                    n_cnt      = '0;
                    n_chk      = 1'b0;
                    if (i_kind == KIND_INSERT || i_kind == KIND_DELETE
                            || i_kind == KIND_LOOKUP) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt != CNT_END) begin
                    mem_re    = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                    n_chk     = 1'b1;
                    n_chk_idx = r_cnt[IDX_W-1:0];
                end else begin
                    // last entry is checked in this cycle
                    n_chk   = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (r_kind == KIND_INSERT) begin
                    if (r_hit) begin
                        done_status = ST_DUP;
                    end else if (!r_free) begin
                        done_status = ST_FULL;
                    end
                end else if (r_kind == KIND_DELETE) begin
                    if (!r_hit) begin
                        done_status = ST_ABSENT;
                    end
                end
                if (!r_out_valid || !i_stall) begin
                    n_out_valid    = 1'b1;
                    n_status       = done_status;
                    n_match_found  = (r_kind == KIND_LOOKUP) && r_found;
                    n_match_length = (r_kind == KIND_LOOKUP) ? r_best : '0;
                    if (r_kind == KIND_INSERT && !r_hit && r_free) begin
                        mem_we         = 1'b1;
                        mem_waddr      = r_free_idx;
                        mem_wdata.valid = 1'b1;
                        mem_wdata.len   = r_len;
                        mem_wdata.base  = r_key_base;
                    end else if (r_kind == KIND_DELETE && r_hit) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_hit_idx;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_match_found  = r_match_found;
    assign o_match_length = r_match_length;

endmodule

FILE: rtl/iplpm_mem.sv
// ----------------------------------------------------------------------------
// iplpm_mem
// Prefix store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iplpm_mem #(
    parameter int DEPTH = iplpm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  iplpm_pkg::t_entry        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output iplpm_pkg::t_entry        o_rdata
);
    import iplpm_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/iplpm_cmp.sv
// ----------------------------------------------------------------------------
// iplpm_cmp
// Shared compare unit: checks one stored entry against the current key.
// ----------------------------------------------------------------------------
module iplpm_cmp (
    input  iplpm_pkg::t_entry                i_entry,
    input  logic [iplpm_pkg::ADDR_W-1:0]     i_key_base,
    input  logic [iplpm_pkg::LEN_W-1:0]      i_key_len,
    input  logic [iplpm_pkg::ADDR_W-1:0]     i_addr,
    output iplpm_pkg::t_cmp_res              o_res
);
    import iplpm_pkg::*;

    always_comb begin
        o_res.exact  = i_entry.valid && (i_entry.len == i_key_len)
                       && (i_entry.base == i_key_base);
        // stored base already has the bits below its length cleared
        o_res.covers = i_entry.valid
                       && ((i_addr & len_mask(i_entry.len)) == i_entry.base);
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete and lookup beats into the IPv4 prefix table, predicts
// each result from a local copy of the stored prefixes and checks every result
// beat in order, under three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import iplpm_pkg::*;

    localparam int TABLE_SLOTS = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_BEATS = 445;
    localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [LEN_W-1:0]  match_len;
    } t_lpm_result;

    class t_lpm_scoreboard;
        bit              in_use[TABLE_SLOTS];
        bit [ADDR_W-1:0] slot_base[TABLE_SLOTS];
        bit [LEN_W-1:0]  slot_len[TABLE_SLOTS];
        t_lpm_result     expected_results[$];
        int              errors;

        static function bit [ADDR_W-1:0] keep_mask(int unsigned n);
            return ~({ADDR_W{1'b1}} >> n);
        endfunction

        function int find_prefix(bit [ADDR_W-1:0] base, int unsigned plen);
            int i;
            for (i = 0; i < TABLE_SLOTS; i++) begin
                if (in_use[i] && slot_len[i] == plen && slot_base[i] == base) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // apply one accepted beat to the local table and queue its result
        function void note_beat(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                logic [LEN_W-1:0] len_in);
            t_lpm_result     res;
            int unsigned     plen;
            bit [ADDR_W-1:0] base;
            int              hit;
            int              free_slot;
            int              i;
            res = '0;
            plen = (len_in > LEN_MAX) ? 32 : len_in;
            base = addr & keep_mask(plen);
            case (kind)
                KIND_INSERT: begin
                    hit = find_prefix(base, plen);
                    free_slot = -1;
                    for (i = TABLE_SLOTS - 1; i >= 0; i--) begin
                        if (!in_use[i]) begin
                            free_slot = i;
                        end
                    end
                    if (hit >= 0) begin
                        res.status = ST_DUP;
                    end else if (free_slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        in_use[free_slot] = 1'b1;
                        slot_base[free_slot] = base;
                        slot_len[free_slot] = LEN_W'(plen);
                    end
                end
                KIND_DELETE: begin
                    hit = find_prefix(base, plen);
                    if (hit < 0) begin
                        res.status = ST_ABSENT;
                    end else begin
                        in_use[hit] = 1'b0;
                        slot_base[hit] = '0;
                        slot_len[hit] = '0;
                    end
                end
                KIND_LOOKUP: begin
                    for (i = 0; i < TABLE_SLOTS; i++) begin
                        if (in_use[i] && (addr & keep_mask(slot_len[i])) == slot_base[i]) begin
                            if (!res.found || slot_len[i] > res.match_len) begin
                                res.match_len = slot_len[i];
                            end
                            res.found = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_beat(logic [STAT_W-1:0] status, logic found,
                                 logic [LEN_W-1:0] match_len);
            t_lpm_result want;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing pending: status %0d found %0d length %0d",
                       status, found, match_len);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (found !== want.found) begin
                $error("match_found mismatch: expected %0d, actual %0d", want.found, found);
                errors++;
            end
            if (match_len !== want.match_len) begin
                $error("match_length mismatch: expected %0d, actual %0d",
                       want.match_len, match_len);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [KIND_W-1:0] i_kind = '0;
    logic [ADDR_W-1:0] i_address = '0;
    logic [LEN_W-1:0]  i_prefix_length = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic              o_match_found;
    logic [LEN_W-1:0]  o_match_length;

    t_lpm_scoreboard   sb = new;
    int                send_idle_pct = 10;
    int                recv_stall_pct = 75;
    int                cycle_count = 0;
    logic [ADDR_W-1:0] roots[4];

    ipv4_longest_prefix_match_table #(
        .TABLE_ENTRIES(TABLE_SLOTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_prefix_length(i_prefix_length),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_match_found  (o_match_found),
        .o_match_length (o_match_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_beat(o_status, o_match_found, o_match_length);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                             logic [LEN_W-1:0] plen);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_address <= addr;
        i_prefix_length <= plen;
        do @(posedge i_clk); while (o_stall);
        sb.note_beat(kind, addr, plen);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // mostly prefixes nested under a few roots or already stored, some noise
    function automatic void draw_op(input int unsigned ins_pct, input int unsigned del_pct,
                                    output logic [KIND_W-1:0] kind,
                                    output logic [ADDR_W-1:0] addr,
                                    output logic [LEN_W-1:0] plen);
        int unsigned       r;
        int unsigned       pick;
        int unsigned       start;
        int unsigned       j;
        int unsigned       n;
        int                stored;
        logic [ADDR_W-1:0] noise;
        logic [ADDR_W-1:0] st_addr;
        logic [LEN_W-1:0]  st_len;
        r = $urandom_range(99);
        pick = $urandom_range(9);
        noise = $urandom();
        n = $urandom_range(32);
        addr = roots[$urandom_range(3)] ^ (noise & ~t_lpm_scoreboard::keep_mask(n));
        plen = LEN_W'(n);
        stored = -1;
        start = $urandom_range(TABLE_SLOTS - 1);
        for (j = 0; j < TABLE_SLOTS; j++) begin
            if (stored < 0 && sb.in_use[(start + j) % TABLE_SLOTS]) begin
                stored = (start + j) % TABLE_SLOTS;
            end
        end
        st_addr = addr;
        st_len = plen;
        if (stored >= 0) begin
            st_len = sb.slot_len[stored];
            st_addr = sb.slot_base[stored] | (noise & ~t_lpm_scoreboard::keep_mask(st_len));
            // a full-length prefix may also be named by an oversized length
            if (st_len == LEN_MAX && noise[0]) begin
                st_len = LEN_W'($urandom_range(33, 63));
            end
        end
        if (r < 2) begin
            kind = KIND_UNDEF;
            addr = noise;
            plen = LEN_W'($urandom_range(63));
        end else if (r < 2 + ins_pct) begin
            kind = KIND_INSERT;
            if (pick < 2) begin
                addr = noise;
                plen = LEN_W'($urandom_range(63));
            end else if (pick < 4) begin
                addr = st_addr;
                plen = st_len;
            end
        end else if (r < 2 + ins_pct + del_pct) begin
            kind = KIND_DELETE;
            if (pick < 6) begin
                addr = st_addr;
                plen = st_len;
            end else if (pick < 7) begin
                addr = noise;
                plen = LEN_W'($urandom_range(63));
            end
        end else begin
            kind = KIND_LOOKUP;
            plen = LEN_W'($urandom_range(63));
            if (pick < 3) begin
                addr = noise;
            end else if (pick < 7) begin
                addr = st_addr;
            end
        end
    endfunction

    initial begin
        int                phase;
        int                i;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  plen;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats
        send_beat(KIND_LOOKUP, 32'h0000_0000, 6'd0);
        send_beat(KIND_DELETE, 32'h0A00_0000, 6'd8);
        send_beat(KIND_INSERT, 32'h0000_0000, 6'd0);
        send_beat(KIND_INSERT, 32'hFFFF_FFFF, 6'd0);
        send_beat(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63);
        send_beat(KIND_INSERT, 32'h0A01_0203, 6'd8);
        send_beat(KIND_INSERT, 32'h0A00_0000, 6'd8);
        send_beat(KIND_INSERT, 32'h0A01_0000, 6'd16);
        send_beat(KIND_INSERT, 32'h0A01_0203, 6'd32);
        send_beat(KIND_INSERT, 32'h0A01_0203, 6'd63);
        send_beat(KIND_LOOKUP, 32'h0A01_0203, 6'd0);
        send_beat(KIND_LOOKUP, 32'h0A01_0204, 6'd0);
        send_beat(KIND_LOOKUP, 32'h0A02_0000, 6'd0);
        send_beat(KIND_LOOKUP, 32'h0B00_0000, 6'd0);
        send_beat(KIND_UNDEF, 32'hFFFF_FFFF, 6'd63);
        send_beat(KIND_DELETE, 32'h0A01_0203, 6'd40);
        send_beat(KIND_LOOKUP, 32'h0A01_0203, 6'd0);
        send_beat(KIND_DELETE, 32'h0A01_0203, 6'd32);
        send_beat(KIND_DELETE, 32'h1234_5678, 6'd0);
        send_beat(KIND_LOOKUP, 32'h0102_0304, 6'd0);
        send_beat(KIND_INSERT, 32'hFFFF_FFFF, 6'd32);
        send_beat(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0);

        for (phase = 0; phase < 3; phase++) begin
            wait_for_drain();
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 75 : 0;
            recv_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 10 : 0;
            for (i = 0; i < 4; i++) begin
                roots[i] = $urandom();
            end
            // alternate fill and drain stretches so the table runs full and empty
            for (i = 0; i < PHASE_BEATS; i++) begin
                if ((i / 75) % 2 == 0) begin
                    draw_op(60, 10, kind, addr, plen);
                end else begin
                    draw_op(12, 50, kind, addr, plen);
                end
                send_beat(kind, addr, plen);
            end
        end

        wait_for_drain();
        repeat (TABLE_SLOTS + 8) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/iplpm_pkg.sv
rtl/iplpm_mem.sv
rtl/iplpm_cmp.sv
rtl/ipv4_longest_prefix_match_table.sv
sim/testbench.sv
